// File: hw/rtl/tfn_pkg.sv
// Shared constants and payload types of the triangle face normal unit.
package tfn_pkg;

	// vertex store and coordinate format
	localparam int VERTEX_DEPTH = 1024;
	localparam int COORD_WIDTH  = 16;
	localparam int ADDR_W       = $clog2(VERTEX_DEPTH);

	// port field widths
	localparam int SLOT_W  = 10;
	localparam int FIELD_W = 16;
	localparam int NORM_W  = 16;
	localparam int FRAC_W  = 14;

	// datapath widths
	localparam int EDGE_W  = COORD_WIDTH + 1;
	localparam int CROSS_W = 2 * EDGE_W + 1;
	localparam int MAG_W   = 2 * COORD_WIDTH + 2;
	localparam int HALF_W  = MAG_W / 2;
	localparam int MUL_W   = HALF_W + 1;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int SQ_W    = 2 * MAG_W;
	localparam int SUM_W   = SQ_W + 2;
	localparam int QUO_W   = 2 * FRAC_W + 1;
	localparam int ROOT_W  = FRAC_W + 1;
	localparam int STEP_W  = 4;

	// operation codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_FACE = 1'b1;

	typedef struct packed {
		logic                      operation;
		logic [SLOT_W-1:0]         vertex_slot;
		logic signed [FIELD_W-1:0] coord_x;
		logic signed [FIELD_W-1:0] coord_y;
		logic signed [FIELD_W-1:0] coord_z;
		logic [SLOT_W-1:0]         corner_a;
		logic [SLOT_W-1:0]         corner_b;
		logic [SLOT_W-1:0]         corner_c;
	} cmd_t;

	typedef struct packed {
		logic signed [NORM_W-1:0] normal_x;
		logic signed [NORM_W-1:0] normal_y;
		logic signed [NORM_W-1:0] normal_z;
		logic                     degenerate;
	} nrm_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x;
		logic signed [COORD_WIDTH-1:0] y;
		logic signed [COORD_WIDTH-1:0] z;
	} vertex_t;

	// multiplier request and response, tagged with the sequencer step
	typedef struct packed {
		logic                    valid;
		logic [STEP_W-1:0]       step;
		logic signed [MUL_W-1:0] op_a;
		logic signed [MUL_W-1:0] op_b;
	} mul_req_t;

	typedef struct packed {
		logic                     valid;
		logic [STEP_W-1:0]        step;
		logic signed [PROD_W-1:0] prod;
	} mul_rsp_t;

endpackage

// File: hw/rtl/tfn_mul_unit.sv
// Shared signed multiplier with one register stage and a step tag.
module tfn_mul_unit
	import tfn_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic                     valid_s1;
	logic [STEP_W-1:0]        step_s1;
	logic signed [PROD_W-1:0] prod_s1;

	// track which request the product belongs to
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
		end
	end

	// multiply and register
	always_ff @(posedge clk) begin
		step_s1 <= req.step;
		prod_s1 <= req.op_a * req.op_b;
	end

	assign rsp.valid = valid_s1;
	assign rsp.step  = step_s1;
	assign rsp.prod  = prod_s1;

endmodule

// File: hw/rtl/tfn_root_div.sv
// Iterative unit: floor(square * 2^28 / total) by restoring division, then its integer root.
module tfn_root_div
	import tfn_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   square,
	input  logic [SUM_W-1:0]  total,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	localparam int CNT_W = $clog2(QUO_W);
	localparam int REM_W = SUM_W + 1;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_ROOT = 4'b0100,
		S_DONE = 4'b1000
	} rd_state_t;

	rd_state_t          state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SUM_W-1:0]   rem_q;
	logic [QUO_W-1:0]   nlo_q;
	logic [QUO_W-1:0]   quo_q;
	logic [QUO_W-1:0]   rad_q;
	logic [QUO_W-1:0]   res_q;
	logic [QUO_W-1:0]   bit_q;

	logic [REM_W-1:0]   trial;
	logic [REM_W-1:0]   trial_diff;
	logic               trial_ge;
	logic [QUO_W-1:0]   quo_next;
	logic [QUO_W:0]     root_sum;
	logic               root_fit;

	// one division step: shift in the next numerator bit, subtract when it fits; and one root trial
	always_comb begin
		trial      = {rem_q, nlo_q[QUO_W-1]};
		trial_ge   = trial >= {1'b0, total};
		trial_diff = trial - {1'b0, total};
		quo_next   = {quo_q[QUO_W-2:0], trial_ge};
		root_sum   = {1'b0, res_q} + {1'b0, bit_q};
		root_fit   = {1'b0, rad_q} >= root_sum;
	end

	// sequence division then root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_DIV;
						cnt_q   <= CNT_W'(QUO_W - 1);
					end
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						state_q <= S_ROOT;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_ROOT: begin
					if (bit_q[0]) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				rem_q <= SUM_W'(square >> 1);
				nlo_q <= {square[0], {(QUO_W-1){1'b0}}};
				quo_q <= '0;
			end
			S_DIV: begin
				rem_q <= trial_ge ? trial_diff[SUM_W-1:0] : trial[SUM_W-1:0];
				nlo_q <= nlo_q << 1;
				quo_q <= quo_next;
				rad_q <= quo_next;
				res_q <= '0;
				bit_q <= {1'b1, {(QUO_W-1){1'b0}}};
			end
			S_ROOT: begin
				if (root_fit) begin
					rad_q <= rad_q - root_sum[QUO_W-1:0];
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			S_DONE: begin
				rem_q <= rem_q;
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	assign done = (state_q == S_DONE);
	assign root = res_q[ROOT_W-1:0];

endmodule

// File: hw/rtl/triangle_face_normal_unit.sv
// Top level: vertex store, face sequencer, shared multiplier and divide/root unit.
//
//   channel | direction | handshake            | payload
//   cmd     | in        | cmd_valid, cmd_stall | cmd_t: vertex load or face
//   nrm     | out       | nrm_valid, nrm_stall | nrm_t: unit normal, degenerate
//
// A vertex load gives no item. A face reads its corners and forms the edges, runs
// the cross product and then the squares on the shared multiplier, then makes 3
// passes through the divide/root unit (29 divide steps and 15 root steps each).
// A degenerate face skips the squares and the passes.
// Reset clears the sequencer and the output valid; the vertex store holds no reset.
// cmd_stall is high while a face is in work; a stalled result waits in the output
// register and holds the next face at its end.
module triangle_face_normal_unit
	import tfn_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_stall,
	input  cmd_t cmd,
	output logic nrm_valid,
	input  logic nrm_stall,
	output nrm_t nrm
);

	localparam int CROSS_OPS  = 6;
	localparam int SQUARE_OPS = 9;

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b0000000001,
		ST_RD_A   = 10'b0000000010,
		ST_RD_B   = 10'b0000000100,
		ST_RD_C   = 10'b0000001000,
		ST_EDGE   = 10'b0000010000,
		ST_CROSS  = 10'b0000100000,
		ST_CHECK  = 10'b0001000000,
		ST_SQUARE = 10'b0010000000,
		ST_SOLVE  = 10'b0100000000,
		ST_HOLD   = 10'b1000000000
	} tfn_state_t;

	// which component and which partial product a square step covers
	function automatic logic [1:0] sq_comp(input logic [STEP_W-1:0] step);
		logic [1:0] c;
		case (step) inside
			[4'd0:4'd2]: c = 2'd0;
			[4'd3:4'd5]: c = 2'd1;
			default:     c = 2'd2;
		endcase
		return c;
	endfunction

	function automatic logic [1:0] sq_part(input logic [STEP_W-1:0] step);
		logic [1:0] p;
		case (step) inside
			4'd0, 4'd3, 4'd6: p = 2'd0;
			4'd1, 4'd4, 4'd7: p = 2'd1;
			default:          p = 2'd2;
		endcase
		return p;
	endfunction

	function automatic logic in_range(input logic [SLOT_W-1:0] idx);
		return 32'(idx) < VERTEX_DEPTH;
	endfunction

	tfn_state_t               state_q;
	logic [STEP_W-1:0]        step_q;
	logic [1:0]               comp_q;
	logic                     launch_q;
	logic                     nrm_valid_q;
	nrm_t                     nrm_q;

	logic [SLOT_W-1:0]        corner_a_q;
	logic [SLOT_W-1:0]        corner_b_q;
	logic [SLOT_W-1:0]        corner_c_q;

	vertex_t                  mem [VERTEX_DEPTH];
	vertex_t                  rd_q;
	logic                     ok_q;
	logic [SLOT_W-1:0]        mem_idx;
	logic [ADDR_W-1:0]        mem_addr;
	logic                     mem_we;
	vertex_t                  mem_wdata;
	logic signed [EDGE_W-1:0] rd_e [3];

	logic signed [EDGE_W-1:0]  va_q [3];
	logic signed [EDGE_W-1:0]  e1_q [3];
	logic signed [EDGE_W-1:0]  e2_q [3];
	logic signed [CROSS_W-1:0] acc_q;
	logic signed [CROSS_W-1:0] cr_q [3];
	logic signed [CROSS_W-1:0] cr_abs [3];
	logic [MAG_W-1:0]          mag_q [3];
	logic                      neg_q [3];
	logic [SQ_W-1:0]           sq_q [3];
	logic [SUM_W-1:0]          s_q;
	logic signed [NORM_W-1:0]  norm_q [3];
	logic                      deg_q;

	mul_req_t                  mul_req;
	mul_rsp_t                  mul_rsp;
	logic [1:0]                iss_comp;
	logic [1:0]                iss_part;
	logic [1:0]                arr_comp;
	logic [1:0]                arr_part;
	logic [SQ_W-1:0]           sq_term;
	logic                      cross_zero;

	logic                      rd_done;
	logic [ROOT_W-1:0]         rd_root;
	logic signed [NORM_W-1:0]  root_val;

	logic                      cmd_take;
	logic                      out_free;

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_take  = cmd_valid && !cmd_stall;
	assign out_free  = !nrm_valid_q || !nrm_stall;

	// pick the store address: a load writes its slot, a face reads its corners
	always_comb begin
		unique case (state_q)
			ST_RD_A: mem_idx = corner_a_q;
			ST_RD_B: mem_idx = corner_b_q;
			ST_RD_C: mem_idx = corner_c_q;
			default: mem_idx = cmd.vertex_slot;
		endcase
		mem_addr        = ADDR_W'(mem_idx);
		mem_we          = cmd_take && (cmd.operation == OP_LOAD) && in_range(cmd.vertex_slot);
		mem_wdata.x     = COORD_WIDTH'(cmd.coord_x);
		mem_wdata.y     = COORD_WIDTH'(cmd.coord_y);
		mem_wdata.z     = COORD_WIDTH'(cmd.coord_z);
	end

	// vertex store with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rd_q <= mem[mem_addr];
		ok_q <= in_range(mem_idx);
	end

	// sign-extend the read vertex; a corner beyond the store reads as zero
	always_comb begin
		rd_e[0] = ok_q ? EDGE_W'(rd_q.x) : '0;
		rd_e[1] = ok_q ? EDGE_W'(rd_q.y) : '0;
		rd_e[2] = ok_q ? EDGE_W'(rd_q.z) : '0;
	end

	// issue multiplies: cross terms, then squares in 17-bit halves
	always_comb begin
		iss_comp     = sq_comp(step_q);
		iss_part     = sq_part(step_q);
		mul_req      = '0;
		mul_req.step = step_q;
		if (state_q == ST_CROSS && step_q < STEP_W'(CROSS_OPS)) begin
			mul_req.valid = 1'b1;
			case (step_q)
				4'd0:    begin mul_req.op_a = MUL_W'(e1_q[1]); mul_req.op_b = MUL_W'(e2_q[2]); end
				4'd1:    begin mul_req.op_a = MUL_W'(e1_q[2]); mul_req.op_b = MUL_W'(e2_q[1]); end
				4'd2:    begin mul_req.op_a = MUL_W'(e1_q[2]); mul_req.op_b = MUL_W'(e2_q[0]); end
				4'd3:    begin mul_req.op_a = MUL_W'(e1_q[0]); mul_req.op_b = MUL_W'(e2_q[2]); end
				4'd4:    begin mul_req.op_a = MUL_W'(e1_q[0]); mul_req.op_b = MUL_W'(e2_q[1]); end
				default: begin mul_req.op_a = MUL_W'(e1_q[1]); mul_req.op_b = MUL_W'(e2_q[0]); end
			endcase
		end else if (state_q == ST_SQUARE && step_q < STEP_W'(SQUARE_OPS)) begin
			mul_req.valid = 1'b1;
			case (iss_part)
				2'd0: begin
					mul_req.op_a = $signed({1'b0, mag_q[iss_comp][HALF_W-1:0]});
					mul_req.op_b = $signed({1'b0, mag_q[iss_comp][HALF_W-1:0]});
				end
				2'd1: begin
					mul_req.op_a = $signed({1'b0, mag_q[iss_comp][MAG_W-1:HALF_W]});
					mul_req.op_b = $signed({1'b0, mag_q[iss_comp][HALF_W-1:0]});
				end
				default: begin
					mul_req.op_a = $signed({1'b0, mag_q[iss_comp][MAG_W-1:HALF_W]});
					mul_req.op_b = $signed({1'b0, mag_q[iss_comp][MAG_W-1:HALF_W]});
				end
			endcase
		end
	end

	tfn_mul_unit u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// weight an arriving partial square by its place
	always_comb begin
		arr_comp = sq_comp(mul_rsp.step);
		arr_part = sq_part(mul_rsp.step);
		case (arr_part)
			2'd0:    sq_term = SQ_W'($unsigned(mul_rsp.prod));
			2'd1:    sq_term = SQ_W'($unsigned(mul_rsp.prod)) << (HALF_W + 1);
			default: sq_term = SQ_W'($unsigned(mul_rsp.prod)) << (2 * HALF_W);
		endcase
	end

	// magnitudes and the zero test of the cross product
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cr_abs[i] = cr_q[i][CROSS_W-1] ? -cr_q[i] : cr_q[i];
		end
		cross_zero = (cr_q[0] == '0) && (cr_q[1] == '0) && (cr_q[2] == '0);
	end

	tfn_root_div u_root_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (launch_q),
		.square (sq_q[comp_q]),
		.total  (s_q),
		.done   (rd_done),
		.root   (rd_root)
	);

	assign root_val = NORM_W'(rd_root);

	// face sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			comp_q   <= '0;
			launch_q <= 1'b0;
		end else begin
			launch_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_take && cmd.operation == OP_FACE) begin
						state_q <= ST_RD_A;
					end
				end
				ST_RD_A: state_q <= ST_RD_B;
				ST_RD_B: state_q <= ST_RD_C;
				ST_RD_C: state_q <= ST_EDGE;
				ST_EDGE: begin
					state_q <= ST_CROSS;
					step_q  <= '0;
				end
				ST_CROSS: begin
					if (step_q < STEP_W'(CROSS_OPS)) begin
						step_q <= step_q + 1'b1;
					end
					if (mul_rsp.valid && mul_rsp.step == STEP_W'(CROSS_OPS - 1)) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					step_q  <= '0;
					state_q <= cross_zero ? ST_HOLD : ST_SQUARE;
				end
				ST_SQUARE: begin
					if (step_q < STEP_W'(SQUARE_OPS)) begin
						step_q <= step_q + 1'b1;
					end
					if (mul_rsp.valid && mul_rsp.step == STEP_W'(SQUARE_OPS - 1)) begin
						state_q  <= ST_SOLVE;
						comp_q   <= '0;
						launch_q <= 1'b1;
					end
				end
				ST_SOLVE: begin
					if (rd_done) begin
						if (comp_q == 2'd2) begin
							state_q <= ST_HOLD;
						end else begin
							comp_q   <= comp_q + 1'b1;
							launch_q <= 1'b1;
						end
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// face datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				corner_a_q <= cmd.corner_a;
				corner_b_q <= cmd.corner_b;
				corner_c_q <= cmd.corner_c;
			end
			ST_RD_B: begin
				for (int i = 0; i < 3; i++) va_q[i] <= rd_e[i];
			end
			ST_RD_C: begin
				for (int i = 0; i < 3; i++) e1_q[i] <= rd_e[i] - va_q[i];
			end
			ST_EDGE: begin
				for (int i = 0; i < 3; i++) e2_q[i] <= rd_e[i] - va_q[i];
			end
			ST_CROSS: begin
				// even steps hold the first term, odd steps subtract the second
				if (mul_rsp.valid) begin
					if (!mul_rsp.step[0]) begin
						acc_q <= CROSS_W'(mul_rsp.prod);
					end else begin
						cr_q[mul_rsp.step[2:1]] <= acc_q - CROSS_W'(mul_rsp.prod);
					end
				end
			end
			ST_CHECK: begin
				for (int i = 0; i < 3; i++) begin
					mag_q[i]  <= MAG_W'(cr_abs[i]);
					neg_q[i]  <= cr_q[i][CROSS_W-1];
					norm_q[i] <= '0;
				end
				deg_q <= cross_zero;
				s_q   <= '0;
			end
			ST_SQUARE: begin
				// build each square and the running sum of squares
				if (mul_rsp.valid) begin
					sq_q[arr_comp] <= (arr_part == 2'd0) ? sq_term : sq_q[arr_comp] + sq_term;
					s_q            <= s_q + SUM_W'(sq_term);
				end
			end
			ST_SOLVE: begin
				if (rd_done) begin
					norm_q[comp_q] <= neg_q[comp_q] ? -root_val : root_val;
				end
			end
			default: begin
				deg_q <= deg_q;
			end
		endcase
	end

	// output register: load the finished result, drop valid when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nrm_valid_q <= 1'b0;
		end else if (state_q == ST_HOLD && out_free) begin
			nrm_valid_q <= 1'b1;
		end else if (!nrm_stall) begin
			nrm_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_HOLD && out_free) begin
			nrm_q.normal_x   <= norm_q[0];
			nrm_q.normal_y   <= norm_q[1];
			nrm_q.normal_z   <= norm_q[2];
			nrm_q.degenerate <= deg_q;
		end
	end

	assign nrm_valid = nrm_valid_q;
	assign nrm       = nrm_q;

endmodule

// File: tb/triangle_face_normal_unit_test.sv
// Self-checking testbench of the triangle face normal unit: directed table, then random.
`timescale 1ns / 1ps

module triangle_face_normal_unit_test;
	import tfn_pkg::*;

	localparam int RANDOM_ITEMS = 580;
	localparam int HOLD_CYCLES  = 800;
	localparam int QUIET_LIMIT  = 6000;
	localparam int DRAIN_CYCLES = 300;
	localparam int PRINT_LIMIT  = 50;

	typedef struct {
		cmd_t item;
		bit   typed;
		nrm_t want;
	} row_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd       = '0;
	logic nrm_valid;
	logic nrm_stall = 1'b0;
	nrm_t nrm;

	// shadow copy of the vertex store and the normals still owed by the block
	vertex_t           shadow_store [VERTEX_DEPTH];
	bit                written [VERTEX_DEPTH];
	logic [SLOT_W-1:0] written_slots [$];
	nrm_t              pending_normals [$];

	int items_sent  = 0;
	int fault_count = 0;
	bit hold_req    = 1'b0;
	bit steady      = 1'b0;

	triangle_face_normal_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.nrm_valid (nrm_valid),
		.nrm_stall (nrm_stall),
		.nrm       (nrm)
	);

	always #4 clk = ~clk;

	// hold reset low from the start, then release it for good
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	task automatic report_fault(input string msg);
		// keep the log short when the block is badly broken
		if (fault_count < PRINT_LIMIT)
			$display("ERROR at %0t: %s", $realtime, msg);
		fault_count++;
	endtask

	// floor(m * 2^14 / sqrt(s)), bit by bit on squares so that it stays exact
	function automatic logic [15:0] unit_q14(logic [127:0] m, logic [127:0] s);
		logic [127:0] m2, goal, t;
		logic [15:0]  q;
		m2 = m * m;
		if (m2 == s)
			return 16'd16384;
		goal = m2 << 28;
		q = '0;
		for (int b = 13; b >= 0; b--) begin
			t = 128'(q | (16'd1 << b));
			if (s * t * t <= goal)
				q = t[15:0];
		end
		return q;
	endfunction

	// unit normal of the face a, b, c with a as the common origin
	function automatic nrm_t face_normal(vertex_t a, vertex_t b, vertex_t c);
		longint                   e1 [3], e2 [3], cr [3];
		logic [127:0]             mag [3];
		logic [127:0]             sum;
		logic signed [NORM_W-1:0] comp [3];
		logic [15:0]              q;
		e1[0] = longint'(b.x) - longint'(a.x);
		e1[1] = longint'(b.y) - longint'(a.y);
		e1[2] = longint'(b.z) - longint'(a.z);
		e2[0] = longint'(c.x) - longint'(a.x);
		e2[1] = longint'(c.y) - longint'(a.y);
		e2[2] = longint'(c.z) - longint'(a.z);
		cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
		cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
		cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
		if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0)
			return nrm_t'{0, 0, 0, 1'b1};
		sum = '0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = 128'(cr[i] < 0 ? -cr[i] : cr[i]);
			sum += mag[i] * mag[i];
		end
		for (int i = 0; i < 3; i++) begin
			q = unit_q14(mag[i], sum);
			comp[i] = cr[i] < 0 ? -q : q;
		end
		return nrm_t'{comp[0], comp[1], comp[2], 1'b0};
	endfunction

	// a load carries random corners, a face random slot and coordinates
	function automatic cmd_t load_cmd(int slot, vertex_t v);
		cmd_t c;
		c.operation   = OP_LOAD;
		c.vertex_slot = slot;
		c.coord_x     = v.x;
		c.coord_y     = v.y;
		c.coord_z     = v.z;
		c.corner_a    = $urandom_range(0, VERTEX_DEPTH - 1);
		c.corner_b    = $urandom_range(0, VERTEX_DEPTH - 1);
		c.corner_c    = $urandom_range(0, VERTEX_DEPTH - 1);
		return c;
	endfunction

	function automatic cmd_t face_cmd(int a, int b, int c);
		cmd_t f;
		f.operation   = OP_FACE;
		f.vertex_slot = $urandom_range(0, VERTEX_DEPTH - 1);
		f.coord_x     = $urandom_range(0, 65535);
		f.coord_y     = $urandom_range(0, 65535);
		f.coord_z     = $urandom_range(0, 65535);
		f.corner_a    = a;
		f.corner_b    = b;
		f.corner_c    = c;
		return f;
	endfunction

	function automatic row_t load_row(int slot, vertex_t v);
		return '{load_cmd(slot, v), 1'b0, '0};
	endfunction

	function automatic row_t face_row(int a, int b, int c, bit typed, nrm_t want);
		return '{face_cmd(a, b, c), typed, want};
	endfunction

	// mostly zero, sometimes a few cycles, now and then a long stretch
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 4);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [FIELD_W-1:0] pick_coord();
		case ($urandom_range(0, 3))
			0, 1: return $urandom_range(0, 65535);
			2: return int'($urandom_range(0, 1023)) - 512;
			default: begin
				case ($urandom_range(0, 4))
					0: return -32768;
					1: return 32767;
					2: return 0;
					3: return -1;
					default: return 1;
				endcase
			end
		endcase
	endfunction

	function automatic logic [SLOT_W-1:0] any_slot();
		return written_slots[$urandom_range(0, written_slots.size() - 1)];
	endfunction

	// update the shadow store or queue the expected normal of an accepted item
	function automatic void record_item(cmd_t item, bit typed, nrm_t want);
		if (item.operation == OP_LOAD) begin
			shadow_store[item.vertex_slot] = '{item.coord_x, item.coord_y, item.coord_z};
			if (!written[item.vertex_slot]) begin
				written[item.vertex_slot] = 1'b1;
				written_slots.push_back(item.vertex_slot);
			end
		end else begin
			pending_normals.push_back(typed ? want : face_normal(shadow_store[item.corner_a],
				shadow_store[item.corner_b], shadow_store[item.corner_c]));
		end
	endfunction

	// offer one item, hold it until taken, then idle for a random gap unless in the steady stretch
	task automatic offer_item(input cmd_t item, input bit typed, input nrm_t want);
		int gap;
		cmd       <= item;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		record_item(item, typed, want);
		items_sent++;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin : stimulus
		row_t              rows [$];
		vertex_t           v [3];
		logic [SLOT_W-1:0] s [3];
		int                kind, k, base, order;
		bit                hold_done, pause_done;
		hold_done  = 1'b0;
		pause_done = 1'b0;

		// unit axes, orientation, repeated corners, extreme coordinates, collinear corners
		rows.push_back(load_row(0, vertex_t'{0, 0, 0}));
		rows.push_back(load_row(1, vertex_t'{256, 0, 0}));
		rows.push_back(load_row(2, vertex_t'{0, 256, 0}));
		rows.push_back(face_row(0, 1, 2, 1'b1, nrm_t'{0, 0, 16384, 1'b0}));
		rows.push_back(face_row(0, 2, 1, 1'b1, nrm_t'{0, 0, -16384, 1'b0}));
		rows.push_back(face_row(0, 0, 0, 1'b1, nrm_t'{0, 0, 0, 1'b1}));
		rows.push_back(face_row(1, 1, 2, 1'b1, nrm_t'{0, 0, 0, 1'b1}));
		rows.push_back(load_row(1023, vertex_t'{-32768, -32768, -32768}));
		rows.push_back(load_row(682, vertex_t'{32767, -32768, -32768}));
		rows.push_back(load_row(341, vertex_t'{-32768, 32767, -32768}));
		rows.push_back(face_row(1023, 682, 341, 1'b1, nrm_t'{0, 0, 16384, 1'b0}));
		rows.push_back(load_row(512, vertex_t'{-32768, -32768, 32767}));
		rows.push_back(face_row(1023, 341, 512, 1'b1, nrm_t'{16384, 0, 0, 1'b0}));
		rows.push_back(face_row(1023, 512, 682, 1'b1, nrm_t'{0, 16384, 0, 1'b0}));
		rows.push_back(face_row(682, 341, 512, 1'b0, '0));
		rows.push_back(load_row(3, vertex_t'{32767, 32767, 32767}));
		rows.push_back(face_row(1023, 3, 0, 1'b1, nrm_t'{0, 0, 0, 1'b1}));
		rows.push_back(face_row(3, 682, 341, 1'b0, '0));
		rows.push_back(load_row(4, vertex_t'{1, -1, 1}));
		rows.push_back(face_row(0, 4, 1, 1'b0, '0));
		rows.push_back(face_row(2, 0, 1, 1'b0, '0));
		rows.push_back(face_row(4, 3, 1023, 1'b0, '0));

		wait (arst_n === 1'b1);
		@(posedge clk);
		foreach (rows[i])
			offer_item(rows[i].item, rows[i].typed, rows[i].want);

		base = items_sent;
		while (items_sent < base + RANDOM_ITEMS) begin
			steady = items_sent >= base + 300 && items_sent < base + 370;
			kind = $urandom_range(0, 99);
			if (!hold_done && items_sent >= base + 200) begin
				// stall the output for a long stretch while faces keep coming
				hold_done = 1'b1;
				hold_req  = 1'b1;
				repeat (8)
					offer_item(face_cmd(any_slot(), any_slot(), any_slot()), 1'b0, '0);
			end else if (!pause_done && items_sent >= base + 420) begin
				// drain every owed normal before going on
				pause_done = 1'b1;
				cmd_valid <= 1'b0;
				while (pending_normals.size() != 0)
					@(posedge clk);
				@(posedge clk);
			end else if (kind < 60) begin
				// load a fresh triangle, general or collinear, then take its face
				for (int i = 0; i < 3; i++)
					s[i] = $urandom_range(0, VERTEX_DEPTH - 1);
				if (kind < 45) begin
					for (int i = 0; i < 3; i++)
						v[i] = '{pick_coord(), pick_coord(), pick_coord()};
				end else begin
					k = int'($urandom_range(0, 6)) - 3;
					v[0] = '{int'($urandom_range(0, 32000)) - 16000,
						int'($urandom_range(0, 32000)) - 16000,
						int'($urandom_range(0, 32000)) - 16000};
					v[1] = '{int'($urandom_range(0, 200)) - 100,
						int'($urandom_range(0, 200)) - 100,
						int'($urandom_range(0, 200)) - 100};
					v[2] = '{v[0].x + k * v[1].x, v[0].y + k * v[1].y, v[0].z + k * v[1].z};
					v[1] = '{v[0].x + v[1].x, v[0].y + v[1].y, v[0].z + v[1].z};
				end
				for (int i = 0; i < 3; i++)
					offer_item(load_cmd(s[i], v[i]), 1'b0, '0);
				order = $urandom_range(0, 2);
				offer_item(face_cmd(s[order], s[(order + 1) % 3], s[(order + 2) % 3]),
					1'b0, '0);
			end else if (kind < 80) begin
				offer_item(face_cmd(any_slot(), any_slot(), any_slot()), 1'b0, '0);
			end else if (kind < 90) begin
				// replace one vertex and reuse it with two slots already written
				s[0] = $urandom_range(0, VERTEX_DEPTH - 1);
				v[0] = '{pick_coord(), pick_coord(), pick_coord()};
				offer_item(load_cmd(s[0], v[0]), 1'b0, '0);
				offer_item(face_cmd(any_slot(), s[0], any_slot()), 1'b0, '0);
			end else if (kind < 95) begin
				offer_item(load_cmd($urandom_range(0, VERTEX_DEPTH - 1),
					'{pick_coord(), pick_coord(), pick_coord()}), 1'b0, '0);
			end else begin
				s[0] = any_slot();
				offer_item(face_cmd(s[0], any_slot(), s[0]), 1'b0, '0);
			end
		end
		steady = 1'b0;

		// wait out the owed normals, then let the block settle
		cmd_valid <= 1'b0;
		while (pending_normals.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// stall the output at random, hold off on request, run open in the steady stretch
	initial begin : receiver
		int run;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				nrm_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (steady) begin
				nrm_stall <= 1'b0;
				@(posedge clk);
			end else begin
				run = pick_gap();
				if (run > 0) begin
					nrm_stall <= 1'b1;
					repeat (run) @(posedge clk);
				end
				nrm_stall <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	// compare each accepted normal with the oldest one owed
	always @(posedge clk) begin : check_normals
		nrm_t want;
		if (arst_n && nrm_valid && !nrm_stall) begin
			if (pending_normals.size() == 0) begin
				report_fault("normal item with no face waiting");
			end else begin
				want = pending_normals.pop_front();
				if (nrm.normal_x !== want.normal_x)
					report_fault($sformatf("normal_x %0d, expected %0d",
						nrm.normal_x, want.normal_x));
				if (nrm.normal_y !== want.normal_y)
					report_fault($sformatf("normal_y %0d, expected %0d",
						nrm.normal_y, want.normal_y));
				if (nrm.normal_z !== want.normal_z)
					report_fault($sformatf("normal_z %0d, expected %0d",
						nrm.normal_z, want.normal_z));
				if (nrm.degenerate !== want.degenerate)
					report_fault($sformatf("degenerate %b, expected %b",
						nrm.degenerate, want.degenerate));
			end
		end
	end

	// end the run when nothing moves on either channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (nrm_valid && !nrm_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
